// ----- hw/rtl/overlapped_hann_spectrum_db_top_macros.svh -----
// assertion macros used by the checker file
`ifndef OVERLAPPED_HANN_SPECTRUM_DB_TOP_MACROS_SVH
`define OVERLAPPED_HANN_SPECTRUM_DB_TOP_MACROS_SVH

// checked outside reset only
`define OHSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define OHSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/ohsd_pkg.sv -----
package ohsd_pkg;

  localparam int FRAME_SIZE = 128;
  localparam int HOP_LENGTH = 64;
  localparam int HOP_EFF = (HOP_LENGTH >= FRAME_SIZE) ? FRAME_SIZE :
                           ((HOP_LENGTH < 1) ? 1 : HOP_LENGTH);
  localparam int NBINS = FRAME_SIZE / 2;
  localparam int AW = $clog2(FRAME_SIZE);
  localparam int FW = $clog2(FRAME_SIZE + 1);
  localparam int KW = $clog2(NBINS);
  localparam int WIN_DEN = FRAME_SIZE - 1;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W = 17;
  localparam int BIN_W = 6;
  localparam int SKIP_W = 4;
  localparam logic [SKIP_W-1:0] SKIP_RESET = 4'd8;

  localparam int TW_W = 32;
  localparam int WIN_W = 17;
  localparam int XW_W = 16;
  localparam int PROD_W = XW_W + TW_W;
  localparam int ACC_W = PROD_W + AW;
  localparam int MAG_W = ACC_W - 1;

  localparam int SQRT_STEPS = 32;
  localparam int LOG_FRAC = 16;
  localparam int MAC_DRAIN = 3;
  localparam int CNT_W = $clog2(SQRT_STEPS);

  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam logic [63:0] EPS_Q45 = 64'd3518;
  localparam int LOG_OFFSET = 45 * 65536;
  localparam logic signed [51:0] DB_OCT_Q16 = 52'sd101008905;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = -17'sd51200;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 17'sd12288;

  // taylor divisors for cos and sin, term n
  localparam longint DivCos [1:9] = '{ONE_Q30 * 2, ONE_Q30 * 12, ONE_Q30 * 30,
                                      ONE_Q30 * 56, ONE_Q30 * 90, ONE_Q30 * 132,
                                      ONE_Q30 * 182, ONE_Q30 * 240, ONE_Q30 * 306};
  localparam longint DivSin [1:9] = '{ONE_Q30 * 6, ONE_Q30 * 20, ONE_Q30 * 42,
                                      ONE_Q30 * 72, ONE_Q30 * 110, ONE_Q30 * 156,
                                      ONE_Q30 * 210, ONE_Q30 * 272, ONE_Q30 * 342};

  typedef logic [FRAME_SIZE-1:0][TW_W-1:0] tw_tab_t;
  typedef logic [FRAME_SIZE-1:0][WIN_W-1:0] win_tab_t;

  // phase t in q32 turns -> {cos, sin} in q30
  function automatic logic [63:0] trig_q30(input longint unsigned t);
    longint unsigned r;
    longint theta, x2, c, sp, s, co, si;
    logic [1:0] q;
    q = t[31:30];
    r = t & 64'h3FFF_FFFF;
    theta = longint'((r * PI_Q30) >> 31);
    x2 = theta * theta / ONE_Q30;
    c = ONE_Q30;
    sp = ONE_Q30;
    for (int n = 9; n >= 1; n--) begin
      c = ONE_Q30 - (x2 * c) / DivCos[n];
      sp = ONE_Q30 - (x2 * sp) / DivSin[n];
    end
    s = theta * sp / ONE_Q30;
    if (c > ONE_Q30) c = ONE_Q30;
    if (s > ONE_Q30) s = ONE_Q30;
    unique case (q)
      2'd0: begin co = c;  si = s;  end
      2'd1: begin co = -s; si = c;  end
      2'd2: begin co = -c; si = -s; end
      default: begin co = s; si = -c; end
    endcase
    return {co[31:0], si[31:0]};
  endfunction

  function automatic tw_tab_t make_tw(input bit want_sin);
    tw_tab_t tab;
    logic [63:0] cs;
    for (int i = 0; i < FRAME_SIZE; i++) begin
      cs = trig_q30((longint'(i) << 32) / FRAME_SIZE);
      tab[i] = want_sin ? cs[31:0] : cs[63:32];
    end
    return tab;
  endfunction

  function automatic win_tab_t make_win();
    win_tab_t tab;
    logic [63:0] cs;
    longint c, w;
    for (int i = 0; i < FRAME_SIZE; i++) begin
      cs = trig_q30((longint'(i % WIN_DEN) << 32) / WIN_DEN);
      c = longint'($signed(cs[63:32]));
      w = (ONE_Q30 - c + 64'sd16384) >>> 15;
      tab[i] = w[WIN_W-1:0];
    end
    return tab;
  endfunction

  localparam tw_tab_t COS_TAB = make_tw(1'b0);
  localparam tw_tab_t SIN_TAB = make_tw(1'b1);
  localparam win_tab_t WIN_TAB = make_win();

  typedef enum logic [3:0] {
    OP_NONE, OP_ABS, OP_NORM, OP_SQ, OP_SUM, OP_SQRT,
    OP_MAG, OP_LNORM, OP_LSQ, OP_LMUL, OP_STORE
  } post_op_t;

  typedef struct packed {
    logic smp_we;
    logic [AW-1:0] smp_waddr;
    logic mac_en;
    logic [AW-1:0] smp_raddr;
    logic [AW-1:0] win_idx;
    logic [AW-1:0] tw_idx;
    logic acc_clr;
    post_op_t op;
    logic [KW-1:0] spec_addr;
    logic spec_re;
  } dp_cmd_t;

  typedef struct packed {
    logic norm_ok;
    logic lnorm_ok;
  } dp_stat_t;

endpackage

// ----- hw/rtl/ohsd_if.sv -----
interface ohsd_in_if import ohsd_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic chunk_last;
  modport source(output valid, sample, chunk_last, input ready);
  modport sink(input valid, sample, chunk_last, output ready);
endinterface

interface ohsd_out_if import ohsd_pkg::*; ();
  logic valid;
  logic ready;
  logic [BIN_W-1:0] bin_index;
  logic signed [LEVEL_W-1:0] level_db;
  logic last_bin;
  modport source(output valid, bin_index, level_db, last_bin, input ready);
  modport sink(input valid, bin_index, level_db, last_bin, output ready);
endinterface

// ----- hw/rtl/overlapped_hann_spectrum_db_top.sv -----
// Log-magnitude spectrum of a Hann-windowed, overlapped audio frame.
// in_ch carries one Q1.15 sample per transaction, chunk_last on the final
// sample of a chunk. cfg_we/cfg_wdata set the chunk skip (one chunk in N
// passes); write it only while the block is idle.
// A sample that does not complete a frame is stored if its chunk passes. A
// sample that completes the 128-sample frame starts a direct DFT: 64 bins,
// each a multiply-accumulate over all 128 samples, then magnitude, square
// root (32 steps) and log2 (normalize, 16 squaring steps), done by the single
// MAC pipeline and the shared iterative magnitude/log unit. in_ch.ready is
// low meanwhile.
// On the final sample of a passed chunk that completed a frame, out_ch
// delivers 64 transactions, bin 0 first, last_bin on bin 63, each bin read
// from the spectrum memory before it is offered; a stalled receiver holds the
// current bin and the block waits, taking no input until the last bin.
// Reset (rst, synchronous) empties the frame, clears the chunk counter and
// sets the skip to 8; the block is idle and takes input once reset is released.
module overlapped_hann_spectrum_db_top import ohsd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [SKIP_W-1:0] cfg_wdata,
  ohsd_in_if.sink in_ch,
  ohsd_out_if.source out_ch
);

  dp_cmd_t cmd;
  dp_stat_t stat;

  ohsd_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_ch.valid),
    .in_last(in_ch.chunk_last),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_bin(out_ch.bin_index),
    .out_last(out_ch.last_bin),
    .cmd(cmd),
    .stat(stat)
  );

  ohsd_dp u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .sample(in_ch.sample),
    .stat(stat),
    .level_db(out_ch.level_db)
  );

endmodule

// ----- hw/rtl/ohsd_ram.sv -----
module ohsd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/ohsd_ctrl.sv -----
module ohsd_ctrl import ohsd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [SKIP_W-1:0] cfg_wdata,
  input  logic in_valid,
  input  logic in_last,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output logic [BIN_W-1:0] out_bin,
  output logic out_last,
  output dp_cmd_t cmd,
  input  dp_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_DRAIN, S_ABS, S_NORM, S_SQ, S_SUM, S_SQRT,
    S_MAG, S_LNORM, S_LSQ, S_LMUL, S_STORE, S_EMIT_RD, S_EMIT_OUT
  } state_t;

  state_t state;
  logic [SKIP_W-1:0] chunk_skip;
  logic [SKIP_W-1:0] chunk_counter;
  logic chunk_passing;
  logic in_chunk;
  logic [FW-1:0] fill;
  logic [AW-1:0] base;
  logic new_frame_ready;
  logic pend_last;
  logic [AW-1:0] n;
  logic [AW-1:0] tw;
  logic [KW-1:0] k;
  logic [CNT_W-1:0] cnt;

  logic accept;
  logic [SKIP_W-1:0] cnt_inc;
  logic pass_start;
  logic pass_now;
  logic frame_full;
  logic k_last;

  function automatic logic [AW-1:0] wrap_idx(input logic [AW:0] s);
    return (s >= (AW+1)'(FRAME_SIZE)) ? AW'(s - (AW+1)'(FRAME_SIZE)) : s[AW-1:0];
  endfunction

  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;
  assign cnt_inc = chunk_counter + 1'b1;
  assign pass_start = (cnt_inc >= chunk_skip);
  assign pass_now = in_chunk ? chunk_passing : pass_start;
  assign frame_full = (fill == FW'(FRAME_SIZE - 1));
  assign k_last = (k == KW'(NBINS - 1));

  assign out_valid = (state == S_EMIT_OUT);
  assign out_bin = BIN_W'(k);
  assign out_last = k_last;

  always_comb begin
    cmd.smp_we = accept && pass_now;
    cmd.smp_waddr = wrap_idx((AW+1)'(base) + (AW+1)'(fill));
    cmd.mac_en = (state == S_MAC);
    cmd.smp_raddr = wrap_idx((AW+1)'(base) + (AW+1)'(n));
    cmd.win_idx = n;
    cmd.tw_idx = tw;
    cmd.acc_clr = (state == S_MAC) && (n == '0);
    cmd.spec_addr = k;
    cmd.spec_re = (state == S_EMIT_RD);
    unique case (state)
      S_ABS:   cmd.op = OP_ABS;
      S_NORM:  cmd.op = OP_NORM;
      S_SQ:    cmd.op = OP_SQ;
      S_SUM:   cmd.op = OP_SUM;
      S_SQRT:  cmd.op = OP_SQRT;
      S_MAG:   cmd.op = OP_MAG;
      S_LNORM: cmd.op = OP_LNORM;
      S_LSQ:   cmd.op = OP_LSQ;
      S_LMUL:  cmd.op = OP_LMUL;
      S_STORE: cmd.op = OP_STORE;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      chunk_skip <= SKIP_RESET;
      chunk_counter <= '0;
      chunk_passing <= 1'b0;
      in_chunk <= 1'b0;
      fill <= '0;
      base <= '0;
      new_frame_ready <= 1'b0;
      pend_last <= 1'b0;
      n <= '0;
      tw <= '0;
      k <= '0;
      cnt <= '0;
    end else begin
      if (cfg_we) begin
        chunk_skip <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            // pass decision is taken on the first sample of a chunk
            if (!in_chunk) begin
              chunk_counter <= pass_start ? '0 : cnt_inc;
              chunk_passing <= pass_start;
            end
            in_chunk <= !in_last;
            if (pass_now && frame_full) begin
              pend_last <= in_last;
              n <= '0;
              tw <= '0;
              k <= '0;
              state <= S_MAC;
            end else if (pass_now) begin
              fill <= fill + 1'b1;
              if (in_last) begin
                new_frame_ready <= 1'b0;
                if (new_frame_ready) begin
                  k <= '0;
                  state <= S_EMIT_RD;
                end
              end
            end
          end
        end
        S_MAC: begin
          n <= n + 1'b1;
          tw <= wrap_idx((AW+1)'(tw) + (AW+1)'(k));
          if (n == AW'(FRAME_SIZE - 1)) begin
            cnt <= CNT_W'(MAC_DRAIN - 1);
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (cnt == '0) begin
            state <= S_ABS;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_ABS: state <= S_NORM;
        S_NORM: begin
          if (stat.norm_ok) begin
            state <= S_SQ;
          end
        end
        S_SQ: state <= S_SUM;
        S_SUM: begin
          cnt <= CNT_W'(SQRT_STEPS - 1);
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (cnt == '0) begin
            state <= S_MAG;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_MAG: state <= S_LNORM;
        S_LNORM: begin
          if (stat.lnorm_ok) begin
            cnt <= CNT_W'(LOG_FRAC - 1);
            state <= S_LSQ;
          end
        end
        S_LSQ: begin
          if (cnt == '0) begin
            state <= S_LMUL;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_LMUL: state <= S_STORE;
        S_STORE: begin
          if (k_last) begin
            // drop the oldest hop by moving the ring base
            base <= wrap_idx((AW+1)'(base) + (AW+1)'(HOP_EFF));
            fill <= FW'(FRAME_SIZE - HOP_EFF);
            k <= '0;
            if (pend_last) begin
              new_frame_ready <= 1'b0;
              state <= S_EMIT_RD;
            end else begin
              new_frame_ready <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            k <= k + 1'b1;
            n <= '0;
            tw <= '0;
            state <= S_MAC;
          end
        end
        S_EMIT_RD: state <= S_EMIT_OUT;
        S_EMIT_OUT: begin
          if (out_ready) begin
            if (k_last) begin
              state <= S_IDLE;
            end else begin
              k <= k + 1'b1;
              state <= S_EMIT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/ohsd_dp.sv -----
module ohsd_dp import ohsd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  dp_cmd_t cmd,
  input  logic signed [SAMPLE_W-1:0] sample,
  output dp_stat_t stat,
  output logic signed [LEVEL_W-1:0] level_db
);

  logic [SAMPLE_W-1:0] smp_q;

  // mac pipeline
  logic s1_valid, s2_valid, s3_valid;
  logic [AW-1:0] s1_win;
  logic [AW-1:0] s1_tw, s2_tw;
  logic signed [SAMPLE_W+WIN_W:0] wprod;
  logic signed [SAMPLE_W+WIN_W+1:0] wsum;
  logic signed [XW_W-1:0] xw;
  logic signed [PROD_W-1:0] pr, pi;
  logic signed [ACC_W-1:0] acc_re, acc_im;

  // magnitude and log
  logic [MAG_W-1:0] a, b, abor;
  logic [4:0] sh;
  logic [61:0] aa, bb;
  logic [63:0] rem, res, bitv, trial;
  logic [63:0] lw;
  logic [5:0] e;
  logic [31:0] y;
  logic [63:0] ysq;
  logic [32:0] yq;
  logic [LOG_FRAC-1:0] frac;
  logic signed [23:0] ldiff;
  logic signed [51:0] lprod;
  logic signed [52:0] lsum;
  logic signed [20:0] lvl;
  logic signed [LEVEL_W-1:0] lvl_sat;

  ohsd_ram #(.WIDTH(SAMPLE_W), .DEPTH(FRAME_SIZE)) u_frame (
    .clk(clk),
    .we(cmd.smp_we),
    .waddr(cmd.smp_waddr),
    .wdata(sample),
    .re(cmd.mac_en),
    .raddr(cmd.smp_raddr),
    .rdata(smp_q)
  );

  ohsd_ram #(.WIDTH(LEVEL_W), .DEPTH(NBINS)) u_spec (
    .clk(clk),
    .we(cmd.op == OP_STORE),
    .waddr(cmd.spec_addr),
    .wdata(lvl_sat),
    .re(cmd.spec_re),
    .raddr(cmd.spec_addr),
    .rdata(level_db)
  );

  // windowed sample, round half up
  assign wsum = (SAMPLE_W+WIN_W+2)'(wprod) + (SAMPLE_W+WIN_W+2)'(32768);
  assign xw = wsum[XW_W+15:16];

  assign abor = a | b;
  assign stat.norm_ok = (abor[MAG_W-1:31] == '0);
  assign stat.lnorm_ok = lw[63];

  assign trial = res + bitv;
  assign ysq = 64'(y) * 64'(y);
  assign yq = ysq[63:31];
  assign ldiff = $signed({1'b0, e, frac}) - $signed(24'(LOG_OFFSET));
  assign lsum = 53'(lprod) + 53'sd2147483648;
  assign lvl = lsum[52:32];

  always_comb begin
    if (lvl < LEVEL_MIN) begin
      lvl_sat = LEVEL_MIN;
    end else if (lvl > LEVEL_MAX) begin
      lvl_sat = LEVEL_MAX;
    end else begin
      lvl_sat = lvl[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.mac_en;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
    s1_win <= cmd.win_idx;
    s1_tw <= cmd.tw_idx;
    s2_tw <= s1_tw;
    wprod <= $signed(smp_q) * $signed({1'b0, WIN_TAB[s1_win]});
    pr <= xw * $signed(COS_TAB[s2_tw]);
    pi <= xw * $signed(SIN_TAB[s2_tw]);
    if (cmd.acc_clr) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (s3_valid) begin
      acc_re <= acc_re + ACC_W'(pr);
      acc_im <= acc_im - ACC_W'(pi);
    end

    unique case (cmd.op)
      OP_ABS: begin
        a <= acc_re[ACC_W-1] ? MAG_W'(-acc_re) : MAG_W'(acc_re);
        b <= acc_im[ACC_W-1] ? MAG_W'(-acc_im) : MAG_W'(acc_im);
        sh <= '0;
      end
      OP_NORM: begin
        if (!stat.norm_ok) begin
          a <= a >> 1;
          b <= b >> 1;
          sh <= sh + 1'b1;
        end
      end
      OP_SQ: begin
        aa <= 62'(a[30:0]) * 62'(a[30:0]);
        bb <= 62'(b[30:0]) * 62'(b[30:0]);
      end
      OP_SUM: begin
        rem <= 64'(aa) + 64'(bb);
        res <= '0;
        bitv <= 64'd1 << 62;
      end
      OP_SQRT: begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
      end
      OP_MAG: begin
        lw <= (res << sh) + EPS_Q45;
        e <= 6'd63;
      end
      OP_LNORM: begin
        if (lw[63]) begin
          y <= lw[63:32];
          frac <= '0;
        end else begin
          lw <= lw << 1;
          e <= e - 1'b1;
        end
      end
      OP_LSQ: begin
        if (yq[32]) begin
          y <= yq[32:1];
          frac <= {frac[LOG_FRAC-2:0], 1'b1};
        end else begin
          y <= yq[31:0];
          frac <= {frac[LOG_FRAC-2:0], 1'b0};
        end
      end
      OP_LMUL: begin
        lprod <= 52'(ldiff) * DB_OCT_Q16;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hw/rtl/ohsd_checker.sv -----
`include "overlapped_hann_spectrum_db_top_macros.svh"

module ohsd_checker import ohsd_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [BIN_W-1:0] bin_index,
  input logic last_bin
);

  // no input is taken while a spectrum is being delivered
  `OHSD_ASSERT(a_no_overlap, !(out_valid && in_ready), "input ready during output")

  `OHSD_ASSERT(a_last_is_top, (out_valid && last_bin) |-> (bin_index == BIN_W'(NBINS - 1)), "last_bin on wrong bin")

  `OHSD_ASSERT(a_end_of_spectrum, (out_valid && out_ready && last_bin) |=> (!out_valid && in_ready), "no return to idle after last bin")

  // bins come in order, with out_valid low between transactions
  `OHSD_ASSERT(a_bin_order, (out_valid && out_ready && !last_bin) |=> !out_valid ##1 (out_valid && (bin_index == BIN_W'($past(bin_index, 2) + 1'b1))), "bin sequence broken")

  `OHSD_ASSERT_ALWAYS(a_reset_idle, rst |=> (!out_valid && in_ready), "not idle after reset")

endmodule

bind overlapped_hann_spectrum_db_top ohsd_checker u_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .bin_index(out_ch.bin_index),
  .last_bin(out_ch.last_bin)
);
